// File: sv/afc_pkg.sv
`timescale 1ns / 1ps

package afc_pkg;

    // Plane storage and the number of planes that take part in the test.
    localparam int PLANE_REGS  = 6;
    localparam int NUM_PLANES  = 6;
    localparam int TEST_PLANES = (NUM_PLANES > PLANE_REGS) ? PLANE_REGS : NUM_PLANES;

    // Configuration port geometry: one 64-bit register every 8 bytes.
    localparam int DATA_W = 64;
    localparam int ADDR_W = $clog2(PLANE_REGS * 8);
    localparam int IDX_W  = $clog2(PLANE_REGS);

    // The bound -w is brought from Q.4 to the Q.26 scale of the products.
    localparam int RHS_SHIFT = 22;

    // Number of axes.
    localparam int AXES = 3;

    // Datapath word types.
    typedef logic signed [15:0] coord_t;   // Q11.4 coordinate or Q1.14 normal
    typedef logic        [15:0] scale_t;   // unsigned Q8.8
    typedef logic signed [16:0] sum_t;     // corner + position, Q.4
    typedef logic signed [33:0] moved_t;   // moved corner, Q.12
    typedef logic signed [49:0] prod_t;    // normal times corner, Q.26
    typedef logic signed [51:0] lhs_t;     // sum over axes and the bound

    // Packed plane register layout.
    typedef struct packed {
        coord_t w;
        coord_t nz;
        coord_t ny;
        coord_t nx;
    } plane_t;

endpackage

// File: sv/aabb_frustum_cull.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                  | Payload
// box       | in        | box_valid / box_stall      | min_*, max_*, pos_*, scale_*
// result    | out       | result_valid / result_stall| outside
// config    | in        | APB psel / penable / pready| paddr, pwdata, prdata (64 bits)
//
// Five register stages: corner sums, corner scaling, plane products, plane sums,
// and the compare with the output register. One box enters per cycle while the
// pipeline moves. The whole pipeline holds while a finished result is stalled;
// box_stall follows result_stall in that case.
// Reset clears the valid bits and sets every plane register to zero.
module aabb_frustum_cull
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               box_valid,
    output logic                               box_stall,
    input  afc_pkg::coord_t                    min_x,
    input  afc_pkg::coord_t                    min_y,
    input  afc_pkg::coord_t                    min_z,
    input  afc_pkg::coord_t                    max_x,
    input  afc_pkg::coord_t                    max_y,
    input  afc_pkg::coord_t                    max_z,
    input  afc_pkg::coord_t                    pos_x,
    input  afc_pkg::coord_t                    pos_y,
    input  afc_pkg::coord_t                    pos_z,
    input  afc_pkg::scale_t                    scale_x,
    input  afc_pkg::scale_t                    scale_y,
    input  afc_pkg::scale_t                    scale_z,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               outside,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [afc_pkg::ADDR_W-1:0]         paddr,
    input  logic [afc_pkg::DATA_W-1:0]         pwdata,
    output logic [afc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int P = afc_pkg::TEST_PLANES;
    localparam int A = afc_pkg::AXES;

    // Plane registers.
    logic [afc_pkg::DATA_W-1:0] plane_reg  [afc_pkg::PLANE_REGS];
    logic [afc_pkg::IDX_W-1:0]  cfg_idx;
    logic                       cfg_write;

    // Input fields gathered per axis.
    afc_pkg::coord_t min_c [A];
    afc_pkg::coord_t max_c [A];
    afc_pkg::coord_t pos_c [A];
    afc_pkg::scale_t scl_c [A];

    // Pipeline registers.
    logic            advance;
    logic            s1_valid_reg, s1_valid_next;
    afc_pkg::sum_t   s1_lo_reg    [A];
    afc_pkg::sum_t   s1_lo_next   [A];
    afc_pkg::sum_t   s1_hi_reg    [A];
    afc_pkg::sum_t   s1_hi_next   [A];
    afc_pkg::scale_t s1_scale_reg [A];
    afc_pkg::scale_t s1_scale_next[A];

    logic            s2_valid_reg, s2_valid_next;
    afc_pkg::moved_t s2_lo_reg    [A];
    afc_pkg::moved_t s2_lo_next   [A];
    afc_pkg::moved_t s2_hi_reg    [A];
    afc_pkg::moved_t s2_hi_next   [A];

    logic            s3_valid_reg, s3_valid_next;
    afc_pkg::prod_t  s3_prod_reg  [P][A];
    afc_pkg::prod_t  s3_prod_next [P][A];

    logic            s4_valid_reg, s4_valid_next;
    afc_pkg::lhs_t   s4_lhs_reg   [P];
    afc_pkg::lhs_t   s4_lhs_next  [P];
    afc_pkg::lhs_t   s4_rhs_reg   [P];
    afc_pkg::lhs_t   s4_rhs_next  [P];

    logic            result_valid_reg, result_valid_next;
    logic            outside_reg, outside_next;

    // Configuration port: always ready, writes beyond the plane list are dropped.
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[afc_pkg::ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        if (int'(cfg_idx) < afc_pkg::PLANE_REGS)
        begin
            prdata = plane_reg[cfg_idx];
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < afc_pkg::PLANE_REGS; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_write && (int'(cfg_idx) < afc_pkg::PLANE_REGS))
        begin
            plane_reg[cfg_idx] <= pwdata;
        end
    end

    // Gather the per-axis input fields.
    assign min_c[0] = min_x;
    assign min_c[1] = min_y;
    assign min_c[2] = min_z;
    assign max_c[0] = max_x;
    assign max_c[1] = max_y;
    assign max_c[2] = max_z;
    assign pos_c[0] = pos_x;
    assign pos_c[1] = pos_y;
    assign pos_c[2] = pos_z;
    assign scl_c[0] = scale_x;
    assign scl_c[1] = scale_y;
    assign scl_c[2] = scale_z;

    // The whole pipeline moves unless a finished result is held.
    assign advance   = !result_valid_reg || !result_stall;
    assign box_stall = !advance;

    // Stage 1: add the object position to both corners.
    always_comb
    begin
        s1_valid_next = box_valid;
        for (int a = 0; a < A; a++)
        begin
            s1_lo_next[a]    = afc_pkg::sum_t'(min_c[a]) + afc_pkg::sum_t'(pos_c[a]);
            s1_hi_next[a]    = afc_pkg::sum_t'(max_c[a]) + afc_pkg::sum_t'(pos_c[a]);
            s1_scale_next[a] = scl_c[a];
        end
    end

    // Stage 2: scale both moved corners per axis.
    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        for (int a = 0; a < A; a++)
        begin
            s2_lo_next[a] = afc_pkg::moved_t'(s1_lo_reg[a])
                          * afc_pkg::moved_t'($signed({1'b0, s1_scale_reg[a]}));
            s2_hi_next[a] = afc_pkg::moved_t'(s1_hi_reg[a])
                          * afc_pkg::moved_t'($signed({1'b0, s1_scale_reg[a]}));
        end
    end

    // Stage 3: n*c2 + |n|*h2 equals twice n times the max corner for a
    // non-negative normal and twice n times the min corner otherwise. The
    // factor two is dropped on both sides of the test.
    always_comb
    begin
        afc_pkg::coord_t n;
        afc_pkg::moved_t sel;
        s3_valid_next = s2_valid_reg;
        for (int p = 0; p < P; p++)
        begin
            for (int a = 0; a < A; a++)
            begin
                n   = afc_pkg::coord_t'(plane_reg[p][16*a +: 16]);
                sel = n[15] ? s2_lo_reg[a] : s2_hi_reg[a];
                s3_prod_next[p][a] = afc_pkg::prod_t'(n) * afc_pkg::prod_t'(sel);
            end
        end
    end

    // Stage 4: sum the axis products and form the bound -w in Q.26.
    always_comb
    begin
        afc_pkg::plane_t pl;
        s4_valid_next = s3_valid_reg;
        for (int p = 0; p < P; p++)
        begin
            pl             = afc_pkg::plane_t'(plane_reg[p]);
            s4_lhs_next[p] = afc_pkg::lhs_t'(s3_prod_reg[p][0])
                           + afc_pkg::lhs_t'(s3_prod_reg[p][1])
                           + afc_pkg::lhs_t'(s3_prod_reg[p][2]);
            s4_rhs_next[p] = (-afc_pkg::lhs_t'(pl.w)) <<< afc_pkg::RHS_SHIFT;
        end
    end

    // Stage 5: a box is outside when any tested plane fails.
    always_comb
    begin
        result_valid_next = s4_valid_reg;
        outside_next      = 1'b0;
        for (int p = 0; p < P; p++)
        begin
            if (s4_lhs_reg[p] < s4_rhs_reg[p])
            begin
                outside_next = 1'b1;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            s3_valid_reg     <= s3_valid_next;
            s4_valid_reg     <= s4_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_lo_reg    <= s1_lo_next;
            s1_hi_reg    <= s1_hi_next;
            s1_scale_reg <= s1_scale_next;
            s2_lo_reg    <= s2_lo_next;
            s2_hi_reg    <= s2_hi_next;
            s3_prod_reg  <= s3_prod_next;
            s4_lhs_reg   <= s4_lhs_next;
            s4_rhs_reg   <= s4_rhs_next;
            outside_reg  <= outside_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign outside      = outside_reg;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import afc_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int RESET_CYCLES     = 12;
    // Index one past the last plane register; writes there must be dropped.
    localparam int UNUSED_IDX       = PLANE_REGS;
    localparam int UNIT_NORMAL      = 16384;

    // Plane sets that the run loads between phases.
    typedef enum int {
        PLANES_DIRECTED,
        PLANES_AXIS,
        PLANES_RANDOM,
        PLANES_ONES,
        PLANES_MOST_NEG,
        PLANES_MOST_POS
    } plane_set_e;

    // One box request, axis 0 is x, 1 is y and 2 is z.
    typedef struct packed {
        coord_t [2:0] mn;
        coord_t [2:0] mx;
        coord_t [2:0] ps;
        scale_t [2:0] sc;
    } box_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              box_valid    = 1'b0;
    logic              box_stall;
    box_t              cur_box      = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              outside;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    box_t        box_queue[$];
    logic        expected_outside[$];
    logic [63:0] plane_shadow[PLANE_REGS];
    int          snd_idle_pct    = 0;
    int          rcv_idle_pct    = 0;
    bit          long_hold_req   = 1'b0;
    int          long_hold_count = 0;
    int          error_count     = 0;
    int          stuck_cycles    = 0;
    logic        want_outside;

    always #1 clk = ~clk;

    aabb_frustum_cull u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .box_valid    (box_valid),
        .box_stall    (box_stall),
        .min_x        (cur_box.mn[0]),
        .min_y        (cur_box.mn[1]),
        .min_z        (cur_box.mn[2]),
        .max_x        (cur_box.mx[0]),
        .max_y        (cur_box.mx[1]),
        .max_z        (cur_box.mx[2]),
        .pos_x        (cur_box.ps[0]),
        .pos_y        (cur_box.ps[1]),
        .pos_z        (cur_box.ps[2]),
        .scale_x      (cur_box.sc[0]),
        .scale_y      (cur_box.sc[1]),
        .scale_z      (cur_box.sc[2]),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .outside      (outside),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Culls one box against the planes currently held in the shadow copy.
    // Center and half-extent are kept doubled, so the bound is doubled too.
    function automatic logic cull_box(box_t b);
        longint      c2[3];
        longint      h2[3];
        longint      lo;
        longint      hi;
        longint      n;
        longint      lhs;
        longint      rhs;
        logic [63:0] r;
        for (int a = 0; a < 3; a++)
        begin
            lo = (longint'($signed(b.mn[a])) + longint'($signed(b.ps[a])))
                 * longint'({48'd0, b.sc[a]});
            hi = (longint'($signed(b.mx[a])) + longint'($signed(b.ps[a])))
                 * longint'({48'd0, b.sc[a]});
            c2[a] = hi + lo;
            h2[a] = hi - lo;
        end
        for (int p = 0; p < TEST_PLANES; p++)
        begin
            r   = plane_shadow[p];
            lhs = 0;
            rhs = -longint'($signed(r[63:48])) * (longint'(1) <<< 23);
            for (int a = 0; a < 3; a++)
            begin
                n = longint'($signed(r[16*a +: 16]));
                // An inverted box keeps its negative half-extent.
                lhs += n * c2[a] + ((n < 0) ? -n : n) * h2[a];
            end
            if (lhs < rhs)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] pack_plane(int nx, int ny, int nz, int w);
        return {16'(w), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    // Same corners, position and scale on all three axes.
    function automatic box_t uniform_box(int lo, int hi, int p, int s);
        box_t b;
        for (int a = 0; a < 3; a++)
        begin
            b.mn[a] = coord_t'(lo);
            b.mx[a] = coord_t'(hi);
            b.ps[a] = coord_t'(p);
            b.sc[a] = scale_t'(s);
        end
        return b;
    endfunction

    // Mostly plausible scene boxes, some inverted, the rest raw bit patterns.
    function automatic box_t random_box();
        box_t   b;
        coord_t tmp;
        int     kind;
        int     c;
        int     e;
        int     a;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                c       = int'($urandom_range(6000)) - 3000;
                e       = int'($urandom_range(800));
                b.mn[i] = coord_t'(c - e);
                b.mx[i] = coord_t'(c + e);
                b.ps[i] = coord_t'(int'($urandom_range(6000)) - 3000);
                b.sc[i] = scale_t'($urandom_range(768, 64));
            end
            if (kind < 42)
            begin
                a       = $urandom_range(2);
                tmp     = b.mn[a];
                b.mn[a] = b.mx[a];
                b.mx[a] = tmp;
            end
        end
        return b;
    endfunction

    // Register write: setup cycle, then access cycle; pready is always high.
    task automatic plane_write(int idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < PLANE_REGS)
            plane_shadow[idx] = value;
    endtask

    // Register read, sampled in the middle of the access cycle.
    task automatic plane_readback(int idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 8);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== plane_shadow[idx])
        begin
            $error("prdata mismatch: expected %h, actual %h", plane_shadow[idx], prdata);
            error_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_planes(plane_set_e kind);
        int          w;
        logic [63:0] value;
        w = $urandom_range(8000, 256);
        for (int p = 0; p < PLANE_REGS; p++)
        begin
            case (kind)
                PLANES_DIRECTED:
                    // Plane 1 uses the most negative normal.
                    value = (p == 1) ? pack_plane(-32768, 0, 0, 1600)
                          : pack_plane((p == 0) ? UNIT_NORMAL : 0,
                                       (p == 2) ? UNIT_NORMAL : (p == 3) ? -UNIT_NORMAL : 0,
                                       (p == 4) ? UNIT_NORMAL : (p == 5) ? -UNIT_NORMAL : 0,
                                       1600);
                PLANES_AXIS:
                    value = pack_plane((p == 0) ? UNIT_NORMAL : (p == 1) ? -UNIT_NORMAL : 0,
                                       (p == 2) ? UNIT_NORMAL : (p == 3) ? -UNIT_NORMAL : 0,
                                       (p == 4) ? UNIT_NORMAL : (p == 5) ? -UNIT_NORMAL : 0,
                                       w);
                PLANES_RANDOM:   value = {$urandom, $urandom};
                PLANES_ONES:     value = '1;
                PLANES_MOST_NEG: value = 64'h8000_8000_8000_8000;
                default:         value = 64'h7FFF_7FFF_7FFF_7FFF;
            endcase
            plane_write(p, value);
        end
        for (int p = 0; p < PLANE_REGS; p++)
            plane_readback(p);
    endtask

    // Waits until every request has gone in and every result has come out.
    task automatic wait_for_results();
        do
            @(negedge clk);
        while (box_queue.size() != 0 || box_valid || expected_outside.size() != 0);
    endtask

    task automatic run_batch(int count, int snd_pct, int rcv_pct, bit hold);
        @(negedge clk);
        snd_idle_pct  = snd_pct;
        rcv_idle_pct  = rcv_pct;
        long_hold_req = hold;
        repeat (count)
            box_queue.push_back(random_box());
        wait_for_results();
    endtask

    // Request driver: payload holds while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
            box_valid <= 1'b0;
        else if (!box_valid || !box_stall)
        begin
            if (box_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                cur_box   <= box_queue.pop_front();
                box_valid <= 1'b1;
            end
            else
                box_valid <= 1'b0;
        end
    end

    // Result receiver, with one long hold-off counted here.
    always @(posedge clk)
    begin
        if (long_hold_req && long_hold_count < LONG_HOLD_CYCLES)
        begin
            long_hold_count <= long_hold_count + 1;
            result_stall    <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // Prediction on accepted requests and in-order check of results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (box_valid && !box_stall)
                expected_outside.push_back(cull_box(cur_box));
            if (result_valid && !result_stall)
            begin
                if (expected_outside.size() == 0)
                begin
                    $error("unexpected result: outside=%0d", outside);
                    error_count++;
                end
                else
                begin
                    want_outside = expected_outside.pop_front();
                    if (outside !== want_outside)
                    begin
                        $error("outside mismatch: expected %0d, actual %0d",
                               want_outside, outside);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transfer.
    always @(posedge clk)
    begin
        if ((box_valid && !box_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        box_t b;
        for (int p = 0; p < PLANE_REGS; p++)
            plane_shadow[p] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Planes are all zero after reset, so every box must come out inside.
        @(negedge clk);
        snd_idle_pct = 27;
        rcv_idle_pct = 69;
        box_queue.push_back(uniform_box(0, 0, 0, 0));
        box_queue.push_back(uniform_box(-32768, 32767, 32767, 65535));
        box_queue.push_back(uniform_box(32767, -32768, -32768, 65535));
        box_queue.push_back(uniform_box(-1, -1, -1, 65535));
        wait_for_results();

        // Directed boxes against axis planes whose bound w is 100 units.
        load_planes(PLANES_DIRECTED);
        @(negedge clk);
        b = uniform_box(-160, 160, 0, 256);
        box_queue.push_back(b);
        b.ps[0] = coord_t'(-8000);
        box_queue.push_back(b);
        b.ps[0] = coord_t'(8000);
        box_queue.push_back(b);
        // Touching the planes exactly still counts as inside.
        box_queue.push_back(uniform_box(-1920, -1600, 0, 256));
        box_queue.push_back(uniform_box(-1920, -1601, 0, 256));
        // Inverted boxes: a small one passes, a wide one is culled.
        box_queue.push_back(uniform_box(160, -160, 0, 256));
        box_queue.push_back(uniform_box(3200, -3200, 0, 256));
        box_queue.push_back(uniform_box(20000, 30000, 0, 0));
        box_queue.push_back(uniform_box(-32768, -32768, -32768, 65535));
        box_queue.push_back(uniform_box(32767, 32767, 32767, 65535));
        wait_for_results();

        load_planes(PLANES_AXIS);
        run_batch(140, 27, 69, 1'b0);

        // Second phase: the sender idles more than the receiver.
        load_planes(PLANES_RANDOM);
        run_batch(75, 69, 27, 1'b0);
        load_planes(PLANES_AXIS);
        run_batch(75, 69, 27, 1'b0);

        // Third phase: no idling, extreme plane sets, then a long result hold.
        load_planes(PLANES_ONES);
        run_batch(35, 0, 0, 1'b0);
        load_planes(PLANES_MOST_NEG);
        run_batch(35, 0, 0, 1'b0);
        load_planes(PLANES_MOST_POS);
        run_batch(30, 0, 0, 1'b0);
        load_planes(PLANES_AXIS);
        plane_write(UNUSED_IDX, '1);
        for (int p = 0; p < PLANE_REGS; p++)
            plane_readback(p);
        run_batch(70, 0, 0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_outside.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/afc_pkg.sv
sv/aabb_frustum_cull.sv
tb/sv/tb_top.sv
